// ===== sv/wrsm_pkg.sv =====
// shared types and constants of the weekly relay schedule matcher
`default_nettype none
package wrsm_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int RELAY_COUNT = 4;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ADDED = 2'd0,
      KIND_FULL  = 2'd1,
      KIND_FIRED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [1:0] relay;
      logic       action_on;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [6:0] day_mask;
   } entry_type;

   typedef struct packed {
      cmd_type    command;
      entry_type  entry;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [2:0] now_weekday;
   } req_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      addr;
      entry_type             data;
   } wr_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] entry_index;
      logic [1:0] relay_number;
      logic       relay_level;
      logic [3:0] relay_bits;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } emit_type;

endpackage
`default_nettype wire

// ===== sv/weekly_relay_schedule_matcher.sv =====
// top level of the weekly relay schedule matcher: ports, result register, checks
//
// channel  direction  tuser            tdata / tlast
// req      in         command          schedule entry and tick time fields
// rsp      out        kind             slot, relay, level, relay levels; tlast = last
//
// an add passes through the ADD state and writes its result into the output register;
// a tick scans every stored slot with the single compare unit, which visits one table
// slot per cycle unless a stalled rsp side holds the scan at a fire.
// req_tready is high only while the sequencer is idle; one item is in work at a time.
// a result waits in the output register; a stalled rsp side holds the scan in place at a fire.
// reset is synchronous: empty table, no fired marks, all relays off.
`default_nettype none
module weekly_relay_schedule_matcher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [1:0] new_relay, [2] new_action_on, [7:3] new_hour, [13:8] new_minute,
   // [20:14] new_day_mask, [25:21] now_hour, [31:26] now_minute,
   // [34:32] now_weekday, [39:35] zero
   input  wire logic [39:0] req_tdata,
   // [0] command
   input  wire logic        req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] entry_index, [5:4] relay_number, [6] relay_level, [10:7] relay_bits,
   // [15:11] zero
   output      logic [15:0] rsp_tdata,
   // [1:0] kind
   output      logic [1:0]  rsp_tuser,
   output      logic        rsp_tlast
);

   wrsm_pkg::req_type                  req;
   wrsm_pkg::wr_type                   wr;
   logic [wrsm_pkg::IDX_W-1:0]         rd_addr;
   wrsm_pkg::entry_type                rd_data;
   wrsm_pkg::emit_type                 emit;
   logic                               out_free;
   logic                               rsp_valid_ff;
   wrsm_pkg::result_type               rsp_res_ff;

   always_comb begin
      req.command        = wrsm_pkg::cmd_type'(req_tuser);
      req.entry.relay    = req_tdata[1:0];
      req.entry.action_on = req_tdata[2];
      req.entry.hour     = req_tdata[7:3];
      req.entry.minute   = req_tdata[13:8];
      req.entry.day_mask = req_tdata[20:14];
      req.now_hour       = req_tdata[25:21];
      req.now_minute     = req_tdata[31:26];
      req.now_weekday    = req_tdata[34:32];
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   wrsm_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wrsm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .out_free  (out_free),
      .wr        (wr),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .emit      (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_res_ff <= emit.res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_res_ff.relay_bits, rsp_res_ff.relay_level,
                        rsp_res_ff.relay_number, rsp_res_ff.entry_index};
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tlast  = rsp_res_ff.last;

`ifndef SYNTHESIS
   // one item at a time: the cycle after a transfer the block is busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted while previous item still in work");

   // the sequencer never overwrites a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // add outcomes are always single, final results
   a_add_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == wrsm_pkg::KIND_ADDED || rsp_tuser == wrsm_pkg::KIND_FULL))
      |-> rsp_tlast)
      else $error("add result without tlast");
`endif

endmodule
`default_nettype wire

// ===== sv/wrsm_store.sv =====
// schedule entry table: one write port, one registered read port at the scan address
`default_nettype none
module wrsm_store (
   input  wire logic                           clock,
   input  wire wrsm_pkg::wr_type               wr,
   input  wire logic [wrsm_pkg::IDX_W-1:0]     rd_addr,
   output      wrsm_pkg::entry_type            rd_data
);

   wrsm_pkg::entry_type table_ff [wrsm_pkg::MAX_ENTRIES];
   wrsm_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= table_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/wrsm_seq.sv =====
// sequencer: add handling, one-entry-per-cycle match scan unless the rsp side stalls, relay levels and fired marks
`default_nettype none
module wrsm_seq (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire wrsm_pkg::req_type              req,
   input  wire logic                           out_free,
   output      wrsm_pkg::wr_type               wr,
   output      logic [wrsm_pkg::IDX_W-1:0]     rd_addr,
   input  wire wrsm_pkg::entry_type            rd_data,
   output      wrsm_pkg::emit_type             emit
);

   wrsm_pkg::state_type                    state_ff, state_in;
   wrsm_pkg::req_type                      req_ff, req_in;
   logic [wrsm_pkg::CNT_W-1:0]             count_ff, count_in;
   logic [wrsm_pkg::CNT_W-1:0]             scan_ff, scan_in;
   logic [wrsm_pkg::MAX_ENTRIES-1:0]       marks_ff, marks_in;
   logic [wrsm_pkg::RELAY_COUNT-1:0]       levels_ff, levels_in;
   wrsm_pkg::result_type                   pend_ff, pend_in;
   logic                                   pend_valid_ff, pend_valid_in;

   logic [7:0]                             mask_ext;
   logic                                   day_ok;
   logic                                   match;
   logic [wrsm_pkg::RELAY_COUNT-1:0]       fire_levels;
   logic [wrsm_pkg::IDX_W-1:0]             idx;

   assign idx     = scan_ff[wrsm_pkg::IDX_W-1:0];
   // read one slot ahead so the registered table data lines up with scan_ff
   assign rd_addr = scan_in[wrsm_pkg::IDX_W-1:0];

   // shared compare unit, applied to one table entry per cycle while the scan is not held
   always_comb begin
      mask_ext = {1'b0, rd_data.day_mask};
      day_ok   = (req_ff.now_weekday != 3'd7) && mask_ext[req_ff.now_weekday];
      match    = day_ok && (rd_data.hour == req_ff.now_hour)
                        && (rd_data.minute == req_ff.now_minute);
      // only the addressed relay takes the entry's action; the other levels stay as they are
      for (int i = 0; i < wrsm_pkg::RELAY_COUNT; i++) begin
         fire_levels[i] = (int'(rd_data.relay) == i) ? rd_data.action_on : levels_ff[i];
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      marks_in      = marks_ff;
      levels_in     = levels_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      wr            = '0;
      emit          = '0;
      req_ready     = 1'b0;

      case (state_ff)
         wrsm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in  = req;
               scan_in = '0;
               state_in = (req.command == wrsm_pkg::CMD_ADD) ? wrsm_pkg::ST_ADD
                                                             : wrsm_pkg::ST_SCAN;
            end
         end
         wrsm_pkg::ST_ADD: begin
            if (out_free) begin
               emit.valid            = 1'b1;
               emit.res.relay_number = 2'd0;
               emit.res.relay_level  = 1'b0;
               emit.res.relay_bits   = 4'(levels_ff);
               emit.res.last         = 1'b1;
               if (count_ff < wrsm_pkg::CNT_W'(wrsm_pkg::MAX_ENTRIES)) begin
                  wr.en                 = 1'b1;
                  wr.addr               = count_ff[wrsm_pkg::IDX_W-1:0];
                  wr.data               = req_ff.entry;
                  marks_in[count_ff[wrsm_pkg::IDX_W-1:0]] = 1'b0;
                  count_in              = count_ff + 1'b1;
                  emit.res.kind         = wrsm_pkg::KIND_ADDED;
                  emit.res.entry_index  = 4'(count_ff);
               end else begin
                  emit.res.kind         = wrsm_pkg::KIND_FULL;
                  emit.res.entry_index  = 4'd0;
               end
               state_in = wrsm_pkg::ST_IDLE;
            end
         end
         wrsm_pkg::ST_SCAN: begin
            if (scan_ff == count_ff) begin
               state_in = wrsm_pkg::ST_FLUSH;
            end else if (!match) begin
               marks_in[idx] = 1'b0;
               scan_in       = scan_ff + 1'b1;
            end else if (marks_ff[idx]) begin
               scan_in = scan_ff + 1'b1;
            end else if (!pend_valid_ff || out_free) begin
               // a later fire proves the held one is not the last
               if (pend_valid_ff) begin
                  emit.valid    = 1'b1;
                  emit.res      = pend_ff;
                  emit.res.last = 1'b0;
               end
               pend_in.kind         = wrsm_pkg::KIND_FIRED;
               pend_in.entry_index  = 4'(scan_ff);
               pend_in.relay_number = rd_data.relay;
               pend_in.relay_level  = rd_data.action_on;
               pend_in.relay_bits   = 4'(fire_levels);
               pend_in.last         = 1'b0;
               pend_valid_in        = 1'b1;
               levels_in            = fire_levels;
               marks_in[idx]        = 1'b1;
               scan_in              = scan_ff + 1'b1;
            end
         end
         wrsm_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = wrsm_pkg::ST_IDLE;
            end else if (out_free) begin
               emit.valid    = 1'b1;
               emit.res      = pend_ff;
               emit.res.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = wrsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrsm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wrsm_pkg::ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         marks_ff      <= '0;
         levels_ff     <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         marks_ff      <= marks_in;
         levels_ff     <= levels_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
   end

endmodule
`default_nettype wire
